/* rtl/core/sda_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the segment descriptor allocator
// no dependencies
package sda_pkg;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_RANGE  = 2'd2,
		STAT_ABSENT = 2'd3
	} status_t;

	// operation codes
	localparam logic OP_CREATE = 1'b0;
	localparam logic OP_FREE   = 1'b1;

	// x86 descriptor layout, page granularity and 32-bit size set, present set
	function automatic logic [63:0] pack_descriptor(
		input logic [31:0] base,
		input logic [31:0] limit,
		input logic [4:0]  seg_type,
		input logic [1:0]  ring
	);
		return {base[31:24], 1'b1, 1'b1, 2'b00, limit[31:28], 1'b1, ring, seg_type,
			base[23:0], limit[27:12]};
	endfunction

endpackage

/* rtl/core/sda_free_stack.sv */
`timescale 1ns / 1ps
// free index stack: one synchronous memory plus a high-water rule for slots
// that still hold their power-up contents; standalone, no package needed
module sda_free_stack #(
	parameter int ENTRIES = 128
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_slot,
	input  logic [$clog2(ENTRIES)-1:0] hwm,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_slot,
	input  logic [$clog2(ENTRIES)-1:0] wr_index,
	output logic [$clog2(ENTRIES):0]   pop_index
);
	localparam int IDX_W = $clog2(ENTRIES);

	logic [IDX_W-1:0] stack_mem [ENTRIES];
	logic [IDX_W-1:0] rdata_q;
	logic [IDX_W-1:0] slot_q;
	logic             fresh_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_slot] <= wr_index;
		end
	end

	// registered read port; a slot at or above the high-water mark was never pushed
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= stack_mem[rd_slot];
			slot_q  <= rd_slot;
			fresh_q <= (rd_slot >= hwm);
		end
	end

	// untouched slot i holds i+1
	assign pop_index = fresh_q ? ({1'b0, slot_q} + (IDX_W+1)'(1)) : {1'b0, rdata_q};

endmodule

/* rtl/core/segment_descriptor_allocator_core.sv */
`timescale 1ns / 1ps
// segment descriptor allocator top level
// depends on sda_pkg and sda_free_stack
//
// Keeps ENTRIES x86 segment descriptors with a stack of free indices (1 to ENTRIES-1,
// entries 1 and 2 present after reset). A create word pops an index, packs and stores
// the descriptor and returns selector index*8; a free word checks and releases a
// selector. Each word returns exactly one result word. For each word the free stack
// and present-mark memories are read first; then the block decides, writes back and
// loads the output register. A new word is taken only once the current one completes,
// and completion waits while the output is stalled.
// No clearing pass is needed after reset: power-up contents are tracked with a
// high-water mark of the stack.
module segment_descriptor_allocator_core #(
	parameter int ENTRIES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] seg_base,
	input  logic [31:0] seg_limit,
	input  logic [4:0]  seg_type,
	input  logic [1:0]  seg_ring,
	input  logic [15:0] free_selector,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  selector_out,
	output logic [63:0] descriptor
);
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int SEL_W = IDX_W + 11;

	// stage 1 word
	logic        v_s1;
	logic        op_s1;
	logic [31:0] base_s1;
	logic [31:0] limit_s1;
	logic [4:0]  type_s1;
	logic [1:0]  ring_s1;
	logic [12:0] idx_s1;

	// allocator state
	logic [IDX_W-1:0] stack_top_q;
	logic [IDX_W-1:0] hwm_q;
	logic             kern1_wr_q;
	logic             kern2_wr_q;
	logic             mark_q;
	logic             present_mem [ENTRIES];
	logic [63:0]      desc_mem [ENTRIES];

	// output register
	logic              out_valid_q;
	sda_pkg::status_t  status_q;
	logic [9:0]        sel_out_q;
	logic [63:0]       desc_q;

	logic             accept;
	logic             done;
	logic [IDX_W:0]   pop_index;
	logic [IDX_W-1:0] pop_n;
	logic [IDX_W-1:0] free_n;
	logic [IDX_W-1:0] top_dec;
	logic [IDX_W-1:0] top_inc;
	logic             full;
	logic             pop_bad;
	logic             free_in_range;
	logic             mark_written;
	logic             mark_eff;
	logic             create_ok;
	logic             free_ok;
	logic [SEL_W-1:0] sel_wide;
	sda_pkg::status_t status_n;

	assign accept   = in_valid && !in_stall;
	assign in_stall = v_s1;
	assign done     = v_s1 && (!out_valid_q || !out_stall);

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (done) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			base_s1  <= seg_base;
			limit_s1 <= seg_limit;
			type_s1  <= seg_type;
			ring_s1  <= seg_ring;
			idx_s1   <= free_selector[15:3];
		end
	end

	// free stack memory
	sda_free_stack #(
		.ENTRIES (ENTRIES)
	) u_stack (
		.clk       (clk),
		.rd_en     (accept),
		.rd_slot   (stack_top_q),
		.hwm       (hwm_q),
		.wr_en     (done && free_ok),
		.wr_slot   (top_dec),
		.wr_index  (free_n),
		.pop_index (pop_index)
	);

	// present marks: read on accept, written back on completion
	always_ff @(posedge clk) begin
		if (accept) begin
			mark_q <= present_mem[free_selector[IDX_W+2:3]];
		end
		if (done && create_ok) begin
			present_mem[pop_n] <= 1'b1;
		end else if (done && free_ok) begin
			present_mem[free_n] <= 1'b0;
		end
	end

	// descriptor store
	always_ff @(posedge clk) begin
		if (done && create_ok) begin
			desc_mem[pop_n] <= sda_pkg::pack_descriptor(base_s1, limit_s1, type_s1, ring_s1);
		end
	end

	// decision stage
	always_comb begin
		pop_n         = pop_index[IDX_W-1:0];
		free_n        = idx_s1[IDX_W-1:0];
		top_dec       = (stack_top_q == '0) ? '0 : stack_top_q - IDX_W'(1);
		top_inc       = stack_top_q + IDX_W'(1);
		full          = (stack_top_q >= IDX_W'(ENTRIES - 1));
		pop_bad       = (pop_index == '0) || (pop_index >= (IDX_W+1)'(ENTRIES));
		free_in_range = (idx_s1 != 13'd0) && ({1'b0, idx_s1} < 14'(ENTRIES));
		// an entry above the high-water mark was never allocated
		mark_written  = ((free_n >= IDX_W'(3)) && (free_n <= hwm_q))
			|| ((free_n == IDX_W'(1)) && kern1_wr_q)
			|| ((free_n == IDX_W'(2)) && kern2_wr_q);
		mark_eff      = mark_written ? mark_q
			: ((free_n == IDX_W'(1)) || (free_n == IDX_W'(2)));
		create_ok     = 1'b0;
		free_ok       = 1'b0;
		status_n      = sda_pkg::STAT_OK;
		if (op_s1 == sda_pkg::OP_CREATE) begin
			if (full) begin
				status_n = sda_pkg::STAT_FULL;
			end else if (pop_bad) begin
				status_n = sda_pkg::STAT_RANGE;
			end else begin
				create_ok = 1'b1;
			end
		end else begin
			if (!free_in_range) begin
				status_n = sda_pkg::STAT_RANGE;
			end else if (!mark_eff) begin
				status_n = sda_pkg::STAT_ABSENT;
			end else begin
				free_ok = 1'b1;
			end
		end
		sel_wide = SEL_W'(pop_index) << 3;
	end

	// stack pointer, high-water mark and kernel entry tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_top_q <= IDX_W'(2);
			hwm_q       <= IDX_W'(2);
			kern1_wr_q  <= 1'b0;
			kern2_wr_q  <= 1'b0;
		end else if (done) begin
			if (op_s1 == sda_pkg::OP_CREATE && !full) begin
				stack_top_q <= top_inc;
				if (top_inc > hwm_q) begin
					hwm_q <= top_inc;
				end
			end
			if (free_ok) begin
				stack_top_q <= top_dec;
			end
			if ((create_ok && pop_n == IDX_W'(1)) || (free_ok && free_n == IDX_W'(1))) begin
				kern1_wr_q <= 1'b1;
			end
			if ((create_ok && pop_n == IDX_W'(2)) || (free_ok && free_n == IDX_W'(2))) begin
				kern2_wr_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q  <= status_n;
			sel_out_q <= create_ok ? sel_wide[9:0] : 10'd0;
			desc_q    <= create_ok
				? sda_pkg::pack_descriptor(base_s1, limit_s1, type_s1, ring_s1) : 64'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign selector_out = sel_out_q;
	assign descriptor   = desc_q;

	// checks
	a_hwm_covers_top: assert property (@(posedge clk) disable iff (!arst_n)
		hwm_q >= stack_top_q)
		else $error("high-water mark below stack top");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != sda_pkg::STAT_OK) |-> (sel_out_q == 10'd0 && desc_q == 64'd0))
		else $error("failed word carries nonzero payload");

	a_create_push: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_s1 == sda_pkg::OP_CREATE && !full)
		|=> (stack_top_q == $past(stack_top_q) + IDX_W'(1)))
		else $error("create did not advance stack top");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !v_s1)
		else $error("stage 1 still busy after completion");

endmodule

/* bench/segment_descriptor_allocator_core_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for segment_descriptor_allocator_core: directed table, then phased random words
// depends on sda_pkg and the allocator rtl; holds its own allocator predictor and result scoreboard
module segment_descriptor_allocator_core_tb;

	localparam int ENTRIES      = 128;
	localparam int RANDOM_WORDS = 1600;
	localparam int CALM_WORDS   = 200;
	localparam int TAIL_CYCLES  = 16;
	localparam int CYCLE_LIMIT  = 400000;

	// one input word and one result word
	typedef struct packed {
		logic        op;
		logic [31:0] base;
		logic [31:0] limit;
		logic [4:0]  typ;
		logic [1:0]  ring;
		logic [15:0] sel;
	} seg_word_t;

	typedef struct packed {
		sda_pkg::status_t status;
		logic [9:0]       sel;
		logic [63:0]      desc;
	} seg_result_t;

	// directed row: the word, and a hand-written result where one is given
	typedef struct packed {
		seg_word_t   w;
		logic        typed;
		seg_result_t want;
	} dir_row_t;

	typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} mix_phase_t;

	localparam int DIR_ROWS = 20;

	// walked in order from reset: free stack top at 2, entries 1 and 2 present
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// selector index zero, far out of range, just past the table, never allocated
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0000}, 1'b1,
			'{sda_pkg::STAT_RANGE, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'hffff}, 1'b1,
			'{sda_pkg::STAT_RANGE, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0400}, 1'b1,
			'{sda_pkg::STAT_RANGE, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h03f8}, 1'b1,
			'{sda_pkg::STAT_ABSENT, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0007}, 1'b1,
			'{sda_pkg::STAT_RANGE, 10'd0, 64'h0}},
		// all-zero and all-one fields
		'{'{sda_pkg::OP_CREATE, 32'h0000_0000, 32'h0000_0000, 5'h00, 2'd0, 16'h0000}, 1'b1,
			'{sda_pkg::STAT_OK, 10'd24, 64'h00c0_8000_0000_0000}},
		'{'{sda_pkg::OP_CREATE, 32'hffff_ffff, 32'hffff_ffff, 5'h1f, 2'd3, 16'hffff}, 1'b1,
			'{sda_pkg::STAT_OK, 10'd32, 64'hffcf_ffff_ffff_ffff}},
		'{'{sda_pkg::OP_CREATE, 32'h1234_5678, 32'h00ab_cfff, 5'h1a, 2'd2, 16'h1234}, 1'b0,
			'0},
		// release, double release, then reuse of the same index
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0018}, 1'b1,
			'{sda_pkg::STAT_OK, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0018}, 1'b1,
			'{sda_pkg::STAT_ABSENT, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_CREATE, 32'h8000_0000, 32'h8000_0000, 5'h10, 2'd1, 16'h0000}, 1'b0,
			'0},
		// low selector bits ignored, then both kernel entries released
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0027}, 1'b1,
			'{sda_pkg::STAT_OK, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0008}, 1'b1,
			'{sda_pkg::STAT_OK, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0010}, 1'b1,
			'{sda_pkg::STAT_OK, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_CREATE, 32'h0000_ffff, 32'h0000_0fff, 5'h0b, 2'd0, 16'hffff}, 1'b0,
			'0},
		'{'{sda_pkg::OP_CREATE, 32'hffff_0000, 32'hffff_f000, 5'h13, 2'd3, 16'h0000}, 1'b0,
			'0},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'hf3fb}, 1'b1,
			'{sda_pkg::STAT_RANGE, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h03ff}, 1'b1,
			'{sda_pkg::STAT_ABSENT, 10'd0, 64'h0}},
		'{'{sda_pkg::OP_CREATE, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 5'h05, 2'd1, 16'h5a5a}, 1'b0,
			'0},
		'{'{sda_pkg::OP_FREE, 32'h0, 32'h0, 5'h00, 2'd0, 16'h0080}, 1'b1,
			'{sda_pkg::STAT_ABSENT, 10'd0, 64'h0}}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [31:0] seg_base;
	logic [31:0] seg_limit;
	logic [4:0]  seg_type;
	logic [1:0]  seg_ring;
	logic [15:0] free_selector;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [9:0]  selector_out;
	logic [63:0] descriptor;

	// predictor state: free index stack, its top and the present marks
	int unsigned pool_slots [ENTRIES];
	int unsigned pool_top;
	bit          in_use [ENTRIES];

	seg_result_t pending_results [$];
	mix_phase_t  phase;
	int unsigned phase_left = 0;
	bit          calm = 1'b0;
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned n_created = 0, n_full = 0, n_freed = 0, n_range = 0, n_absent = 0;

	segment_descriptor_allocator_core #(.ENTRIES(ENTRIES)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.seg_base     (seg_base),
		.seg_limit    (seg_limit),
		.seg_type     (seg_type),
		.seg_ring     (seg_ring),
		.free_selector(free_selector),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.selector_out (selector_out),
		.descriptor   (descriptor)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// allocate or release one word and return the result it must produce
	function automatic seg_result_t predict_word(seg_word_t w);
		seg_result_t r;
		int unsigned idx;
		r = '0;
		r.status = sda_pkg::STAT_OK;
		if (w.op == sda_pkg::OP_CREATE) begin
			if (pool_top >= ENTRIES - 1) begin
				r.status = sda_pkg::STAT_FULL;
			end else begin
				idx = pool_slots[pool_top];
				pool_top++;
				if (idx == 0 || idx >= ENTRIES) begin
					r.status = sda_pkg::STAT_RANGE;
				end else begin
					// x86 layout, present, 32-bit size and page granularity set
					r.desc[15:0]  = w.limit[27:12];
					r.desc[39:16] = w.base[23:0];
					r.desc[44:40] = w.typ;
					r.desc[46:45] = w.ring;
					r.desc[47]    = 1'b1;
					r.desc[51:48] = w.limit[31:28];
					r.desc[54]    = 1'b1;
					r.desc[55]    = 1'b1;
					r.desc[63:56] = w.base[31:24];
					in_use[idx] = 1'b1;
					r.sel = 10'(idx << 3);
				end
			end
		end else begin
			idx = w.sel >> 3;
			if (idx == 0 || idx >= ENTRIES) begin
				r.status = sda_pkg::STAT_RANGE;
			end else if (!in_use[idx]) begin
				r.status = sda_pkg::STAT_ABSENT;
			end else begin
				in_use[idx] = 1'b0;
				if (pool_top > 0)
					pool_top--;
				pool_slots[pool_top] = idx;
			end
		end
		return r;
	endfunction

	// random word shaped by phases that fill, drain or mix the table
	function automatic seg_word_t next_random_word();
		seg_word_t w;
		int unsigned live, roll;
		int pick;
		if (phase_left == 0) begin
			phase = mix_phase_t'($urandom_range(0, 2));
			phase_left = $urandom_range(40, 160);
		end
		phase_left--;
		w.base  = $urandom;
		w.limit = $urandom;
		w.typ   = 5'($urandom);
		w.ring  = 2'($urandom);
		w.sel   = 16'($urandom);
		roll = $urandom_range(0, 99);
		case (phase)
			PH_FILL:  w.op = (roll < 90) ? sda_pkg::OP_CREATE : sda_pkg::OP_FREE;
			PH_DRAIN: w.op = (roll < 90) ? sda_pkg::OP_FREE : sda_pkg::OP_CREATE;
			default:  w.op = (roll < 50) ? sda_pkg::OP_CREATE : sda_pkg::OP_FREE;
		endcase
		if (w.op == sda_pkg::OP_CREATE) begin
			// occasional all-zero or all-one fields
			case ($urandom_range(0, 9))
				0: begin
					w.base = '0;
					w.limit = '0;
					w.typ = '0;
					w.ring = '0;
				end
				1: begin
					w.base = '1;
					w.limit = '1;
					w.typ = '1;
					w.ring = '1;
				end
				default: ;
			endcase
		end else begin
			live = 0;
			foreach (in_use[i])
				if (in_use[i])
					live++;
			roll = $urandom_range(0, 99);
			if (roll < 80 && live != 0) begin
				// release a live entry, random low selector bits
				pick = $urandom_range(0, live - 1);
				foreach (in_use[i])
					if (in_use[i]) begin
						if (pick == 0)
							w.sel = {13'(i), w.sel[2:0]};
						pick--;
					end
			end else if (roll < 85) begin
				w.sel = {13'd0, w.sel[2:0]};
			end else if (roll < 90) begin
				w.sel = {13'($urandom_range(ENTRIES, 8191)), w.sel[2:0]};
			end else if (roll < 95) begin
				w.sel = {13'($urandom_range(1, ENTRIES - 1)), w.sel[2:0]};
			end
		end
		return w;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on result %0d, %s: got %h, want %h", results_seen, field, got, want);
		fail_count++;
	endtask

	// result side: compare every accepted word with the oldest expectation
	always @(posedge clk) begin : result_check
		seg_result_t head;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, status", 64'(status), 64'h0);
			end else begin
				head = pending_results.pop_front();
				if (status !== head.status)
					report_mismatch("status", 64'(status), 64'(head.status));
				if (selector_out !== head.sel)
					report_mismatch("selector", 64'(selector_out), 64'(head.sel));
				if (descriptor !== head.desc)
					report_mismatch("descriptor", descriptor, head.desc);
			end
			results_seen++;
		end
	end

	// result side back-pressure in random bursts, none in the calm tail
	initial begin
		int unsigned n;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(50, 200);
			else
				n = $urandom_range(1, 20);
			repeat (n) @(posedge clk);
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still due", cycle_count,
			pending_results.size());
		$display("segment_descriptor_allocator_core_tb failed");
		$finish;
	end

	// input side: reset, directed table, then random words
	initial begin
		seg_word_t   cur;
		seg_result_t due;
		int unsigned gap;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		op            <= sda_pkg::OP_CREATE;
		seg_base      <= '0;
		seg_limit     <= '0;
		seg_type      <= '0;
		seg_ring      <= '0;
		free_selector <= '0;
		for (int i = 0; i < ENTRIES; i++) begin
			pool_slots[i] = i + 1;
			in_use[i] = 1'b0;
		end
		in_use[1] = 1'b1;
		in_use[2] = 1'b1;
		pool_top = 2;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < DIR_ROWS + RANDOM_WORDS; n++) begin
			if (n < DIR_ROWS)
				cur = DIR_TABLE[n].w;
			else
				cur = next_random_word();
			calm = (n >= DIR_ROWS + RANDOM_WORDS - CALM_WORDS);
			gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid      <= 1'b1;
			op            <= cur.op;
			seg_base      <= cur.base;
			seg_limit     <= cur.limit;
			seg_type      <= cur.typ;
			seg_ring      <= cur.ring;
			free_selector <= cur.sel;
			do @(posedge clk); while (in_stall !== 1'b0);
			// word taken at this edge
			due = predict_word(cur);
			if (n < DIR_ROWS && DIR_TABLE[n].typed)
				due = DIR_TABLE[n].want;
			pending_results.push_back(due);
			case (due.status)
				sda_pkg::STAT_OK: begin
					if (cur.op == sda_pkg::OP_CREATE)
						n_created++;
					else
						n_freed++;
				end
				sda_pkg::STAT_FULL:  n_full++;
				sda_pkg::STAT_RANGE: n_range++;
				default:             n_absent++;
			endcase
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d words, %0d results: %0d allocated, %0d released, %0d table full",
			DIR_ROWS + RANDOM_WORDS, results_seen, n_created, n_freed, n_full);
		$display("rejected frees: %0d out of range, %0d not present; %0d mismatches",
			n_range, n_absent, fail_count);
		if (fail_count == 0)
			$display("segment_descriptor_allocator_core_tb passed");
		else
			$display("segment_descriptor_allocator_core_tb failed");
		$finish;
	end

endmodule
